FILE: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 16;

   localparam int CSR_W   = 5;
   localparam int PAGE_W  = 16;
   localparam int FRAME_W = 4;
   localparam int TALLY_W = 32;

   localparam logic [CSR_W-1:0]   CSR_RESET = 5'd16;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   typedef struct packed {
      logic              restart;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [TALLY_W-1:0] fault_total;
   } rsp_type;

endpackage

FILE: rtl/lrupr_cell.sv
// One frame of the replacement table: page, valid mark, recency rank and a search stage.
`timescale 1ns / 1ps

module lrupr_cell
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   parameter int INDEX     = 0,
   localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CW       = $clog2(FRAMES + 1),
   localparam int PROBE_W  = 1 + PAGE_BITS + 3 * (1 + 2 * IW) + PAGE_BITS,
   localparam int UPD_W    = 3 + 2 * IW + PAGE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CW-1:0]      active_count,
   input  logic [UPD_W-1:0]   upd_bits,
   input  logic [PROBE_W-1:0] probe_in_bits,
   output logic [PROBE_W-1:0] probe_out_bits
);

   typedef struct packed {
      logic                 go;
      logic [PAGE_BITS-1:0] page;
      logic                 found;
      logic [IW-1:0]        hit_idx;
      logic [IW-1:0]        hit_rank;
      logic                 empty_found;
      logic [IW-1:0]        empty_idx;
      logic [IW-1:0]        empty_rank;
      logic                 best_found;
      logic [IW-1:0]        best_idx;
      logic [IW-1:0]        best_rank;
      logic [PAGE_BITS-1:0] best_page;
   } probe_type;

   typedef struct packed {
      logic                 clear;
      logic                 apply;
      logic                 write;
      logic [IW-1:0]        frame;
      logic [IW-1:0]        rank;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   probe_type            probe_in;
   probe_type            probe_in_nxt;
   probe_type            probe_ff;
   upd_type              upd;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [IW-1:0]        rank_ff;
   logic                 valid_in;
   logic [IW-1:0]        rank_in;
   logic                 active_here;

   assign probe_in       = probe_type'(probe_in_bits);
   assign upd            = upd_type'(upd_bits);
   assign probe_out_bits = PROBE_W'(probe_ff);
   assign active_here    = INDEX < int'(active_count);

   always_comb begin
      probe_in_nxt = probe_in;
      if (active_here && valid_ff && page_ff == probe_in.page && !probe_in.found) begin
         probe_in_nxt.found    = 1'b1;
         probe_in_nxt.hit_idx  = MY_IDX;
         probe_in_nxt.hit_rank = rank_ff;
      end
      if (active_here && !valid_ff && !probe_in.empty_found) begin
         probe_in_nxt.empty_found = 1'b1;
         probe_in_nxt.empty_idx   = MY_IDX;
         probe_in_nxt.empty_rank  = rank_ff;
      end
      if (active_here && valid_ff &&
          (!probe_in.best_found || rank_ff > probe_in.best_rank)) begin
         probe_in_nxt.best_found = 1'b1;
         probe_in_nxt.best_idx   = MY_IDX;
         probe_in_nxt.best_rank  = rank_ff;
         probe_in_nxt.best_page  = page_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.clear) begin
         valid_in = 1'b0;
         rank_in  = MY_IDX;
      end else if (upd.apply) begin
         if (upd.frame == MY_IDX) begin
            rank_in = '0;
            if (upd.write) begin
               valid_in = 1'b1;
            end
         end else if (rank_ff < upd.rank) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         rank_ff     <= MY_IDX;
         probe_ff.go <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rank_ff     <= rank_in;
         probe_ff.go <= probe_in_nxt.go;
      end
      probe_ff.page        <= probe_in_nxt.page;
      probe_ff.found       <= probe_in_nxt.found;
      probe_ff.hit_idx     <= probe_in_nxt.hit_idx;
      probe_ff.hit_rank    <= probe_in_nxt.hit_rank;
      probe_ff.empty_found <= probe_in_nxt.empty_found;
      probe_ff.empty_idx   <= probe_in_nxt.empty_idx;
      probe_ff.empty_rank  <= probe_in_nxt.empty_rank;
      probe_ff.best_found  <= probe_in_nxt.best_found;
      probe_ff.best_idx    <= probe_in_nxt.best_idx;
      probe_ff.best_rank   <= probe_in_nxt.best_rank;
      probe_ff.best_page   <= probe_in_nxt.best_page;
      if (!upd.clear && upd.apply && upd.write && upd.frame == MY_IDX) begin
         page_ff <= upd.page;
      end
   end

endmodule

FILE: rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: chain of frame cells and sequencing.
`timescale 1ns / 1ps

// Usage:
//   req_valid/req_ready/req_data carry one page reference (restart flag, page).
//   rsp_valid/rsp_ready/rsp_data return one result per reference: hit, frame,
//   evicted page and the saturating fault count.
//   csr_wr_en/csr_wr_data write frames_in_use; write only while the block is idle.
//   A reference travels down a chain of FRAMES cells, one cell per cycle, each
//   folding its frame into the search record; the record is then captured, and
//   once the output register is free the table update is broadcast and the
//   result loaded into it. A new reference is taken only after that load.
//   A finished result waits in the output register; a new reference is taken
//   meanwhile, and the next result is held back until the waiting one transfers.
//   Reset (synchronous, active high) empties all frames, sets ranks to frame
//   order, clears the fault count and sets frames_in_use to 16.
module lru_page_replacement_top
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int IW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW      = $clog2(FRAMES + 1);
   localparam int PROBE_W = 1 + PAGE_BITS + 3 * (1 + 2 * IW) + PAGE_BITS;
   localparam int UPD_W   = 3 + 2 * IW + PAGE_BITS;

   typedef struct packed {
      logic                 go;
      logic [PAGE_BITS-1:0] page;
      logic                 found;
      logic [IW-1:0]        hit_idx;
      logic [IW-1:0]        hit_rank;
      logic                 empty_found;
      logic [IW-1:0]        empty_idx;
      logic [IW-1:0]        empty_rank;
      logic                 best_found;
      logic [IW-1:0]        best_idx;
      logic [IW-1:0]        best_rank;
      logic [PAGE_BITS-1:0] best_page;
   } probe_type;

   typedef struct packed {
      logic                 clear;
      logic                 apply;
      logic                 write;
      logic [IW-1:0]        frame;
      logic [IW-1:0]        rank;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [CSR_W-1:0]   csr_ff;
   logic [TALLY_W-1:0] tally_ff;
   logic [TALLY_W-1:0] tally_in;
   logic [TALLY_W-1:0] tally_next;
   probe_type          launch_ff;
   probe_type          res_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic [CW-1:0]      active_count;
   logic [PROBE_W-1:0] chain [FRAMES+1];
   probe_type          chain_end;
   upd_type            upd;
   logic               accept;
   logic               load;
   logic               evict;
   logic [IW-1:0]      pick_idx;
   logic [IW-1:0]      pick_rank;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign load      = state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign chain[0]  = PROBE_W'(launch_ff);
   assign chain_end = probe_type'(chain[FRAMES]);

   always_comb begin
      if (csr_ff == '0) begin
         active_count = CW'(1);
      end else if (int'(csr_ff) > FRAMES) begin
         active_count = CW'(FRAMES);
      end else begin
         active_count = CW'(csr_ff);
      end
   end

   always_comb begin
      evict = 1'b0;
      if (res_ff.found) begin
         pick_idx  = res_ff.hit_idx;
         pick_rank = res_ff.hit_rank;
      end else if (res_ff.empty_found) begin
         pick_idx  = res_ff.empty_idx;
         pick_rank = res_ff.empty_rank;
      end else begin
         pick_idx  = res_ff.best_idx;
         pick_rank = res_ff.best_rank;
         evict     = 1'b1;
      end
   end

   always_comb begin
      upd.clear = accept && req_data.restart;
      upd.apply = load;
      upd.write = !res_ff.found;
      upd.frame = pick_idx;
      upd.rank  = pick_rank;
      upd.page  = res_ff.page;
   end

   assign tally_next = (!res_ff.found && tally_ff != TALLY_MAX) ? tally_ff + 1'b1 : tally_ff;

   always_comb begin
      state_in     = state_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               if (req_data.restart) begin
                  tally_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (chain_end.go) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in                  = ST_IDLE;
               tally_in                  = tally_next;
               rsp_valid_in              = 1'b1;
               rsp_data_in.hit           = res_ff.found;
               rsp_data_in.frame_index   = FRAME_W'(pick_idx);
               rsp_data_in.evicted_valid = evict;
               rsp_data_in.evicted_page  = evict ? PAGE_W'(res_ff.best_page) : '0;
               rsp_data_in.fault_total   = tally_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= CSR_RESET;
         launch_ff.go <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff.go <= accept;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         launch_ff.page        <= PAGE_BITS'(req_data.page);
         launch_ff.found       <= 1'b0;
         launch_ff.hit_idx     <= '0;
         launch_ff.hit_rank    <= '0;
         launch_ff.empty_found <= 1'b0;
         launch_ff.empty_idx   <= '0;
         launch_ff.empty_rank  <= '0;
         launch_ff.best_found  <= 1'b0;
         launch_ff.best_idx    <= '0;
         launch_ff.best_rank   <= '0;
         launch_ff.best_page   <= '0;
      end
      if (state_ff == ST_SCAN && chain_end.go) begin
         res_ff <= chain_end;
      end
   end

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lrupr_cell #(
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active_count   (active_count),
         .upd_bits       (UPD_W'(upd)),
         .probe_in_bits  (chain[i]),
         .probe_out_bits (chain[i+1])
      );
   end

endmodule

FILE: tb/tb_lru_page_replacement_top.sv
// Testbench for the LRU page replacement block: references checked against a page table tracker.
`timescale 1ns / 1ps

module tb_lru_page_replacement_top;
   import lrupr_pkg::*;

   localparam int FRAMES      = FRAMES_DEF;
   localparam int LATENCY     = FRAMES + 3;
   localparam int PHASES      = 10;
   localparam int PHASE_REFS  = 75;
   localparam int HOLD_CYCLES = 400;

   class lru_table_tracker;
      logic [PAGE_W-1:0]  frame_page[FRAMES];
      bit                 frame_used[FRAMES];
      logic [FRAME_W-1:0] frame_rank[FRAMES];
      logic [TALLY_W-1:0] fault_count;
      logic [CSR_W-1:0]   frames_in_use;
      rsp_type            outcomes[$];
      int unsigned        fails;

      function new();
         frames_in_use = CSR_RESET;
         fails = 0;
         clear_table();
      endfunction

      function void clear_table();
         for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 0;
            frame_rank[i] = FRAME_W'(i);
         end
         fault_count = '0;
      endfunction

      function int unsigned active_frames();
         if (frames_in_use == 0) return 1;
         if (frames_in_use > FRAMES) return FRAMES;
         return 32'(frames_in_use);
      endfunction

      function int unsigned pending();
         return outcomes.size();
      endfunction

      function void note_reference(req_type r);
         rsp_type            o;
         int unsigned        act;
         int unsigned        f;
         bit                 located;
         bit                 empty_seen;
         logic [FRAME_W-1:0] old_rank;
         o = '0;
         f = 0;
         located = 0;
         empty_seen = 0;
         if (r.restart) clear_table();
         act = active_frames();
         for (int i = 0; i < act; i++)
            if (!located && frame_used[i] && frame_page[i] == r.page) begin
               f = i;
               located = 1;
            end
         if (located) begin
            o.hit = 1;
         end else begin
            for (int i = 0; i < act; i++)
               if (!empty_seen && !frame_used[i]) begin
                  f = i;
                  empty_seen = 1;
               end
            if (!empty_seen) begin
               f = 0;
               for (int i = 1; i < act; i++)
                  if (frame_rank[i] > frame_rank[f]) f = i;
               o.evicted_valid = 1;
               o.evicted_page = frame_page[f];
            end
            frame_page[f] = r.page;
            frame_used[f] = 1;
            if (fault_count != TALLY_MAX) fault_count++;
         end
         old_rank = frame_rank[f];
         for (int i = 0; i < FRAMES; i++)
            if (frame_rank[i] < old_rank) frame_rank[i]++;
         frame_rank[f] = '0;
         o.frame_index = FRAME_W'(f);
         o.fault_total = fault_count;
         outcomes.push_back(o);
      endfunction

      function void mismatch(string field, logic [TALLY_W-1:0] want, logic [TALLY_W-1:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fails++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (outcomes.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
            fails++;
            return;
         end
         want = outcomes.pop_front();
         if (want.hit !== got.hit)
            mismatch("hit", TALLY_W'(want.hit), TALLY_W'(got.hit));
         if (want.frame_index !== got.frame_index)
            mismatch("frame_index", TALLY_W'(want.frame_index), TALLY_W'(got.frame_index));
         if (want.evicted_valid !== got.evicted_valid)
            mismatch("evicted_valid", TALLY_W'(want.evicted_valid),
                     TALLY_W'(got.evicted_valid));
         if (want.evicted_page !== got.evicted_page)
            mismatch("evicted_page", TALLY_W'(want.evicted_page), TALLY_W'(got.evicted_page));
         if (want.fault_total !== got.fault_total)
            mismatch("fault_total", want.fault_total, got.fault_total);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   lru_table_tracker tracker;
   int unsigned      send_idle_pct = 25;
   int unsigned      recv_idle_pct = 77;
   int unsigned      hold_asks = 0;
   logic [CSR_W-1:0] frame_settings[PHASES];

   lru_page_replacement_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) tracker.note_reference(req_data);
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
   end

   initial begin
      int unsigned seen_asks;
      int unsigned hold_left;
      seen_asks = 0;
      hold_left = 0;
      rsp_ready <= 0;
      forever begin
         @(posedge clock);
         if (hold_asks != seen_asks) begin
            seen_asks = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_ready <= 0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_ref(input bit restart, input logic [PAGE_W-1:0] page);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{restart: restart, page: page};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_frames(input logic [CSR_W-1:0] value);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      tracker.frames_in_use = value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      int unsigned       span;
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] page;
      bit                restart;
      tracker = new();
      frame_settings = '{5'd1, 5'd0, 5'd3, 5'd31, 5'd17, 5'd15, 5'd2, 5'd16, 5'd8, 5'd5};
      base = '0;
      reset <= 1;
      req_valid <= 0;
      req_data <= '0;
      csr_wr_en <= 0;
      csr_wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      send_ref(0, 16'h0000);
      send_ref(0, 16'hFFFF);
      for (int p = 1; p < FRAMES - 1; p++) send_ref(0, PAGE_W'(p));
      send_ref(0, 16'h0000);
      send_ref(0, 16'h8000);
      send_ref(0, 16'h0001);
      send_ref(1, 16'hAAAA);
      send_ref(0, 16'hAAAA);
      send_ref(1, 16'hAAAA);
      send_ref(0, 16'h5555);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         write_frames(frame_settings[ph]);
         if (ph < 4) begin
            send_idle_pct = 25;
            recv_idle_pct = 77;
         end else if (ph < 7) begin
            send_idle_pct = 77;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 7) hold_asks++;
         if (ph % 2 == 0) base = PAGE_W'($urandom);
         for (int n = 0; n < PHASE_REFS; n++) begin
            span = tracker.active_frames() + $urandom_range(4);
            restart = ($urandom_range(99) < 2);
            if ($urandom_range(9) == 0) page = PAGE_W'($urandom);
            else page = base + PAGE_W'($urandom_range(span - 1));
            send_ref(restart, page);
         end
      end

      wait_idle();
      if (tracker.fails == 0 && tracker.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement_top.sv
tb/tb_lru_page_replacement_top.sv
